@@ hdl/dcrmf_pkg.sv @@
// shared types and constants for the d-choice relaxed multi-lane fifo
package dcrmf_pkg;

	localparam int LANES_DEFAULT       = 8;
	localparam int LANE_DEPTH_DEFAULT  = 64;
	localparam int MAX_CHOICES_DEFAULT = 4;

	localparam logic [2:0] CHOICES_RESET = 3'd2;

	// operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] value_in;
		logic [2:0]  choice_0;
		logic [2:0]  choice_1;
		logic [2:0]  choice_2;
		logic [2:0]  choice_3;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value_out;
		logic        empty_flag;
		logic        dropped_flag;
		logic [2:0]  lane_used;
	} out_item_t;

endpackage

@@ hdl/d_choice_relaxed_multi_fifo.sv @@
// d-choice relaxed multi-lane fifo: top level
//
// A relaxed fifo made of LANES sub-fifos of LANE_DEPTH words each. Every
// item is an enqueue or a dequeue that names up to four candidate lanes;
// the first n of them are compared, n being the choices register clamped
// to 1..MAX_CHOICES. An enqueue goes to the candidate with the smallest
// running enqueue count (earlier candidate wins a tie) and is dropped with
// dropped_flag set if that lane is full. A dequeue walks the candidates by
// running dequeue count, skipping empty ones, and reports empty_flag without
// falling back if the chosen lane is empty. Per-lane bookkeeping (head,
// tail, fill, counts) lives in a small metadata memory read one candidate
// per cycle; the payload lives in a second memory of LANES*LANE_DEPTH words.
// One item is in flight at a time: a new item is accepted only once the last
// has put its result in the output register, and the n candidates are read
// one after another through the single read port of the metadata memory. The
// result waits in an output register, so a stalled consumer only holds the
// block once a second result is ready. Metadata entries carry valid bits
// cleared by reset, so the block takes items right after reset with no
// clearing pass; the choices register resets to 2.
module d_choice_relaxed_multi_fifo
	import dcrmf_pkg::*;
#(
	parameter int LANES       = LANES_DEFAULT,
	parameter int LANE_DEPTH  = LANE_DEPTH_DEFAULT,
	parameter int MAX_CHOICES = MAX_CHOICES_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	// configuration
	input  logic      cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	// input channel
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	// output channel
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int LW = $clog2(LANES);
	localparam int PW = $clog2(LANE_DEPTH);
	localparam int FW = $clog2(LANE_DEPTH + 1);
	localparam int AW = $clog2(LANES * LANE_DEPTH);

	// per-lane bookkeeping word
	typedef struct packed {
		logic [31:0]   enq_total;
		logic [31:0]   deq_total;
		logic [FW-1:0] fill;
		logic [PW-1:0] head;
		logic [PW-1:0] tail;
	} meta_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EXEC,
		ST_RDATA
	} state_t;

	// choice index modulo LANES, by repeated subtraction on three bits
	function automatic logic [LW-1:0] lane_of(input logic [2:0] c);
		logic [2:0] v;
		v = c;
		for (int k = 0; k < 4; k++) begin
			if (int'(v) >= LANES) begin
				v = v - 3'(LANES);
			end
		end
		return LW'(v);
	endfunction

	// ring position advance
	function automatic logic [PW-1:0] wrap_pos(input logic [PW-1:0] p);
		return (p == PW'(LANE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	state_t        state_q;
	logic [2:0]    choices_q;
	logic [1:0]    idx_q;        // index of the candidate whose data arrives
	logic [1:0]    nlast_q;      // index of the last compared candidate
	logic          out_valid_q;
	out_item_t     out_item_q;

	logic          op_q;
	logic [31:0]   value_q;
	logic [LW-1:0] cand_q [4];   // candidates not yet read, front first
	logic [LW-1:0] look_lane_q;  // lane of the metadata now arriving
	logic [LW-1:0] cur_q;        // current choice
	meta_t         best_q;       // metadata of the current choice

	// metadata memory, valid bits in flops
	meta_t         meta_mem [LANES];
	logic          vld_q [LANES];
	meta_t         meta_rd_s1;
	logic          meta_vld_s1;

	// payload memory
	logic [31:0]   slot_mem [LANES * LANE_DEPTH];
	logic [31:0]   slot_rd_s1;

	// ------------------------------------------------------------------
	// combinational control
	// ------------------------------------------------------------------
	logic          in_accept;
	logic [2:0]    n_eff;
	logic          meta_re;
	logic [LW-1:0] meta_ra;
	meta_t         look_data;
	logic          take;
	logic          last;
	meta_t         next_best;
	logic [LW-1:0] next_cur;
	logic          out_free;
	logic          res_load;
	logic          lane_full;
	logic          lane_empty;
	logic          meta_we;
	meta_t         meta_wd;
	logic          slot_we;
	logic          slot_re;
	logic [AW-1:0] lane_base;
	logic [AW-1:0] slot_addr;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// clamp the choices register into 1..MAX_CHOICES
	always_comb begin
		priority if (choices_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (int'(choices_q) > MAX_CHOICES) begin
			n_eff = 3'(MAX_CHOICES);
		end else begin
			n_eff = choices_q;
		end
	end

	// one metadata read per candidate: first at accept, then one per look cycle but the last
	assign last    = (idx_q == nlast_q);
	assign meta_re = in_accept || (state_q == ST_LOOK && !last);
	assign meta_ra = (state_q == ST_IDLE) ? lane_of(in_item.choice_0) : cand_q[0];

	// never-written lanes read as all zero
	assign look_data = meta_vld_s1 ? meta_rd_s1 : '0;

	// candidate comparison, one candidate per cycle
	always_comb begin
		priority if (idx_q == 2'd0) begin
			take = 1'b1;
		end else if (op_q == OP_ENQ) begin
			take = (look_data.enq_total < best_q.enq_total);
		end else if (best_q.fill == '0) begin
			take = 1'b1;      // empty current choice is replaced
		end else if (look_data.fill == '0) begin
			take = 1'b0;      // empty candidate is skipped
		end else begin
			take = (look_data.deq_total < best_q.deq_total);
		end
	end

	assign next_best = take ? look_data : best_q;
	assign next_cur  = take ? look_lane_q : cur_q;

	// execute step: the output register must be free by the next edge
	assign out_free   = !out_valid_q || !out_stall;
	assign lane_full  = (best_q.fill >= FW'(LANE_DEPTH));
	assign lane_empty = (best_q.fill == '0);

	// a result goes into the output register this cycle
	assign res_load = out_free && (((state_q == ST_EXEC) && ((op_q == OP_ENQ) || lane_empty))
		|| (state_q == ST_RDATA));

	assign slot_we = (state_q == ST_EXEC) && out_free && (op_q == OP_ENQ) && !lane_full;
	assign slot_re = (state_q == ST_EXEC) && out_free && (op_q == OP_DEQ) && !lane_empty;
	assign meta_we = slot_we || slot_re;

	// lane base times a constant, then the ring position
	assign lane_base = AW'(cur_q) * AW'(LANE_DEPTH);
	assign slot_addr = lane_base + AW'((op_q == OP_ENQ) ? best_q.tail : best_q.head);

	// updated bookkeeping for the chosen lane
	always_comb begin
		meta_wd = best_q;
		if (op_q == OP_ENQ) begin
			meta_wd.tail      = wrap_pos(best_q.tail);
			meta_wd.fill      = best_q.fill + FW'(1);
			meta_wd.enq_total = best_q.enq_total + 32'd1;
		end else begin
			meta_wd.head      = wrap_pos(best_q.head);
			meta_wd.fill      = best_q.fill - FW'(1);
			meta_wd.deq_total = best_q.deq_total + 32'd1;
		end
	end

	// ------------------------------------------------------------------
	// configuration register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			choices_q <= CHOICES_RESET;
		end else if (cfg_wr_en) begin
			choices_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------
	// sequencer with the output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			nlast_q     <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			// new result loaded, or the waiting one taken by the consumer
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						idx_q   <= '0;
						nlast_q <= 2'(n_eff - 3'd1);
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					idx_q <= idx_q + 2'd1;
					if (last) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						if (op_q == OP_ENQ) begin
							out_item_q.value_out    <= '0;
							out_item_q.empty_flag   <= 1'b0;
							out_item_q.dropped_flag <= lane_full;
							out_item_q.lane_used    <= 3'(cur_q);
							state_q                 <= ST_IDLE;
						end else if (lane_empty) begin
							out_item_q.value_out    <= '0;
							out_item_q.empty_flag   <= 1'b1;
							out_item_q.dropped_flag <= 1'b0;
							out_item_q.lane_used    <= 3'(cur_q);
							state_q                 <= ST_IDLE;
						end else begin
							state_q <= ST_RDATA;
						end
					end
				end
				ST_RDATA: begin
					// read data stays put until the next slot read
					if (out_free) begin
						out_item_q.value_out    <= slot_rd_s1;
						out_item_q.empty_flag   <= 1'b0;
						out_item_q.dropped_flag <= 1'b0;
						out_item_q.lane_used    <= 3'(cur_q);
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// item payload and candidate walk
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q        <= in_item.opcode;
			value_q     <= in_item.value_in;
			look_lane_q <= lane_of(in_item.choice_0);
			cand_q[0]   <= lane_of(in_item.choice_1);
			cand_q[1]   <= lane_of(in_item.choice_2);
			cand_q[2]   <= lane_of(in_item.choice_3);
			cand_q[3]   <= lane_of(in_item.choice_3);
		end else if (state_q == ST_LOOK) begin
			best_q <= next_best;
			cur_q  <= next_cur;
			if (!last) begin
				// pop the candidate whose read goes out now
				look_lane_q <= cand_q[0];
				cand_q[0]   <= cand_q[1];
				cand_q[1]   <= cand_q[2];
				cand_q[2]   <= cand_q[3];
			end
		end
	end

	// ------------------------------------------------------------------
	// metadata memory
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (meta_re) begin
			meta_rd_s1  <= meta_mem[meta_ra];
			meta_vld_s1 <= vld_q[meta_ra];
		end
		if (meta_we) begin
			meta_mem[cur_q] <= meta_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (meta_we) begin
			vld_q[cur_q] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// payload memory
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_addr] <= value_q;
		end
		if (slot_re) begin
			slot_rd_s1 <= slot_mem[slot_addr];
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		meta_we |-> (meta_wd.fill <= FW'(LANE_DEPTH)))
		else $error("lane fill above depth");

	a_one_slot_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(slot_we && slot_re))
		else $error("slot write and read in one cycle");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_item_q.empty_flag && out_item_q.dropped_flag))
		else $error("empty and dropped both set");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> (idx_q <= nlast_q))
		else $error("candidate walk past last choice");

	a_read_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		slot_re |=> (state_q == ST_RDATA))
		else $error("slot read without data step");

endmodule
